// ----- sv/wpim_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wpim_pkg;

  // pattern storage
  localparam int PatCap   = 32;
  localparam int CharW    = 8;
  localparam int CfgW     = 64;
  localparam int CfgIdxW  = 3;
  localparam int LenW     = 6;
  localparam int BytesPerReg = CfgW / CharW;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_A   = 3'd0,
    CFG_PAT_B   = 3'd1,
    CFG_PAT_C   = 3'd2,
    CFG_PAT_D   = 3'd3,
    CFG_PAT_LEN = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CharW-1:0] word_char;
    logic             last_char;
  } in_word_t;

  typedef struct packed {
    logic            is_match;
    logic [LenW-1:0] word_length;
    logic            too_long;
  } out_word_t;

  // broadcast from the top to every cell
  typedef struct packed {
    logic             step;
    logic             last;
    logic [CharW-1:0] ch;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/wpim_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wpim_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  wpim_pkg::cell_ctrl_t      ctrl_i,
  input  logic                      prev_used_i,
  input  logic [wpim_pkg::CharW-1:0] pat_char_i,
  input  logic [wpim_pkg::CharW-1:0] pat_cur_i,
  output logic                      used_o,
  output logic [wpim_pkg::CharW-1:0] pat_sel_o,
  output logic                      bad_o
);
  import wpim_pkg::*;

  logic             used_q, used_d;
  logic [CharW-1:0] char_q;
  logic             tok;
  logic             eq_word, eq_pat;

  // write slot sits at the edge of the used thermometer
  assign tok = prev_used_i & ~used_q;

  assign eq_word = (char_q == ctrl_i.ch);
  assign eq_pat  = (pat_char_i == pat_cur_i);

  // this position must see the incoming char exactly as the pattern does
  assign bad_o     = used_q & (eq_word ^ eq_pat);
  assign pat_sel_o = tok ? pat_char_i : '0;
  assign used_o    = used_q;

  always_comb begin
    used_d = used_q;
    if (ctrl_i.step) begin
      if (ctrl_i.last) begin
        used_d = 1'b0;
      end else begin
        used_d = used_q | tok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step && tok) begin
      char_q <= ctrl_i.ch;
    end
  end

endmodule

`default_nettype wire

// ----- sv/word_pattern_isomorphism_match_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// word pattern matcher: takes one character word per cycle, the last char of each
// source word flagged, and gives one result word per source word (match flag,
// length saturating at MAX_LEN, too-long flag) in the cycle after its last char is
// taken. a source word matches when it has the pattern's length and the same
// letter structure (equal chars exactly where the pattern has equal chars).
// the current word lives in a row of MAX_LEN cells; a used-bit thermometer runs
// through the row and its edge marks the cell that takes the next char. every
// cell compares its stored char with the incoming one in the same cycle, so a
// char is taken every cycle when not stalled; that compare across the whole row and
// its or-reduction set the cycle. input stalls only while a finished result is
// held by output stall; chars that do not end a word still wait behind it.
// pattern registers should be written only while no word is in flight.
module word_pattern_isomorphism_match_core #(
  parameter int MAX_LEN = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [wpim_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wpim_pkg::CfgW-1:0]     cfg_wdata_i,
  // char stream in
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wpim_pkg::in_word_t            in_word_i,
  // result out
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wpim_pkg::out_word_t           out_word_o
);
  import wpim_pkg::*;

  localparam int PosW = $clog2(MAX_LEN + 1);

  // pattern registers
  logic [3:0][CfgW-1:0] pattern_q;
  logic [LenW-1:0]      pat_len_q;
  logic [LenW-1:0]      plen;

  // word tracking
  logic [PosW-1:0] char_position_q, char_position_d;
  logic            mismatch_q, mismatch_d;
  logic            overflow_q, overflow_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q;
  out_word_t result;

  logic             in_acc;
  logic             full;
  logic             any_bad;
  logic             mis_now, ovf_now;
  logic [PosW-1:0]  len_now;
  logic [6:0]       len_ext;
  logic [CharW-1:0] pat_cur;
  cell_ctrl_t       ctrl;

  logic [MAX_LEN-1:0]            used_vec;
  logic [MAX_LEN-1:0]            prev_used_vec;
  logic [MAX_LEN-1:0]            bad_vec;
  logic [MAX_LEN-1:0][CharW-1:0] pat_sel_vec;
  logic [MAX_LEN-1:0][CharW-1:0] pat_char_vec;

  // ---------------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      pat_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAT_A:   pattern_q[0] <= cfg_wdata_i;
        CFG_PAT_B:   pattern_q[1] <= cfg_wdata_i;
        CFG_PAT_C:   pattern_q[2] <= cfg_wdata_i;
        CFG_PAT_D:   pattern_q[3] <= cfg_wdata_i;
        CFG_PAT_LEN: pat_len_q    <= cfg_wdata_i[LenW-1:0];
        default:     ;
      endcase
    end
  end

  // lengths past the pattern capacity count as full capacity
  assign plen = (pat_len_q > LenW'(PatCap)) ? LenW'(PatCap) : pat_len_q;

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign ctrl.step = in_acc;
  assign ctrl.last = in_word_i.last_char;
  assign ctrl.ch   = in_word_i.word_char;

  // ---------------------------------------------------------------------------
  // cell row
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign prev_used_vec[k] = 1'b1;
    end else begin : g_link
      assign prev_used_vec[k] = used_vec[k-1];
    end

    // positions beyond the pattern never decide a match (length check does)
    if (k < PatCap) begin : g_pat
      assign pat_char_vec[k] =
        pattern_q[k / BytesPerReg][(k % BytesPerReg) * CharW +: CharW];
    end else begin : g_nopat
      assign pat_char_vec[k] = '0;
    end

    wpim_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_used_i (prev_used_vec[k]),
      .pat_char_i  (pat_char_vec[k]),
      .pat_cur_i   (pat_cur),
      .used_o      (used_vec[k]),
      .pat_sel_o   (pat_sel_vec[k]),
      .bad_o       (bad_vec[k])
    );
  end

  // pattern char at the current position, picked by the one-hot write slot
  always_comb begin
    pat_cur = '0;
    for (int k = 0; k < MAX_LEN; k++) begin
      pat_cur = pat_cur | pat_sel_vec[k];
    end
  end

  assign any_bad = |bad_vec;
  assign full    = used_vec[MAX_LEN-1];

  // ---------------------------------------------------------------------------
  // per-char verdict and word state
  // ---------------------------------------------------------------------------
  always_comb begin
    if (full) begin
      mis_now = 1'b1;
      ovf_now = 1'b1;
      len_now = char_position_q;
    end else begin
      mis_now = mismatch_q | any_bad | (7'(char_position_q) >= 7'(plen));
      ovf_now = overflow_q;
      len_now = char_position_q + PosW'(1);
    end
  end

  assign len_ext = 7'(len_now);

  assign result.is_match    = ~mis_now & ~ovf_now & (len_ext == 7'(plen));
  assign result.word_length = len_ext[LenW-1:0];
  assign result.too_long    = ovf_now;

  always_comb begin
    char_position_d = char_position_q;
    mismatch_d      = mismatch_q;
    overflow_d      = overflow_q;
    if (in_acc) begin
      if (in_word_i.last_char) begin
        char_position_d = '0;
        mismatch_d      = 1'b0;
        overflow_d      = 1'b0;
      end else begin
        char_position_d = len_now;
        mismatch_d      = mis_now;
        overflow_d      = ovf_now;
      end
    end
  end

  // output slot: loaded on a word's last char, drained when not stalled
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc && in_word_i.last_char) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_position_q <= '0;
      mismatch_q      <= 1'b0;
      overflow_q      <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      char_position_q <= char_position_d;
      mismatch_q      <= mismatch_d;
      overflow_q      <= overflow_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_word_i.last_char) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef NO_ASSERTIONS
  // used bits form a thermometer from cell 0
  a_used_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_vec & ~prev_used_vec) == '0)
    else $error("used bits not contiguous");

  // cell row and position counter agree
  a_used_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_vec) == int'(char_position_q))
    else $error("cell row disagrees with char position");

  // a word end clears the row and the counter
  a_word_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.last_char) |=> (used_vec == '0 && char_position_q == '0))
    else $error("word state not cleared after last char");

  // a too-long word never reports a match
  a_long_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_word_q.is_match && out_word_q.too_long))
    else $error("too-long word flagged as match");
`endif

endmodule

`default_nettype wire
